// ===== rtl/set_assoc_lru_writeback_cache_assert.svh =====
// Assertion macros shared by the cache checker.
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_ASSERT_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SALC_ASSERT_IMP(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("salc check failed");
// Next-cycle implication checked outside reset.
`define SALC_ASSERT_NXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("salc check failed");
`endif

// ===== rtl/salc_pkg.sv =====
// Shared types and constants for the set-associative LRU write-back cache.
package salc_pkg;
  localparam int AddrW = 32;
  localparam int WayOutW = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DECIDE,
    ST_WRITE
  } back_state_t;

  localparam logic OP_READ = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Front-to-back queue entry
  typedef struct packed {
    logic op;
    logic [AddrW-1:0] addr;
  } req_t;
endpackage

// ===== rtl/salc_front.sv =====
// Front end: takes commands and holds them in a two-entry queue.
module salc_front
  import salc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic op,
  input  logic [AddrW-1:0] addr,
  output logic busy,
  output logic q_valid,
  output req_t q_data,
  input  logic q_pop
);
  req_t q_mem [2];
  logic rd_ptr;
  logic wr_ptr;
  logic [1:0] count;
  logic push;

  assign busy = (count == 2'd2);
  assign push = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_data = q_mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= '{op: op, addr: addr};
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ===== rtl/salc_back.sv =====
// Back end: tag lookup, LRU update and fill, one set row at a time.
module salc_back
  import salc_pkg::*;
#(
  parameter int SETS = 16,
  parameter int WAYS = 8,
  parameter int BLOCK_BYTES = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  req_t q_data,
  output logic q_pop,
  output logic done,
  output logic is_write,
  output logic hit,
  output logic write_back,
  output logic [WayOutW-1:0] way_used
);
  localparam int OB = $clog2(BLOCK_BYTES + 1) - 1;
  localparam int SB = $clog2(SETS + 1) - 1;
  localparam int NSETS = 1 << SB;
  localparam int SIW = (SB > 0) ? SB : 1;
  localparam int TW = AddrW - OB - SB;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RW = $clog2(WAYS + 1);

  typedef logic [WAYS-1:0][TW-1:0] tag_row_t;

  back_state_t state, state_next;
  req_t cur;
  logic [SIW-1:0] set_idx;
  logic [TW-1:0] tag;

  // per-set valid/dirty/rank rows in flops; tags in a memory
  logic [WAYS-1:0] valid_r [NSETS];
  logic [WAYS-1:0] dirty_r [NSETS];
  logic [RW-1:0] rank_r [NSETS][WAYS];
  tag_row_t tag_mem [NSETS];
  tag_row_t tag_row;

  logic [WAYS-1:0] vrow, drow;
  logic [RW-1:0] rrow [WAYS];
  logic d_hit, d_free, d_wb;
  logic [WW-1:0] d_way;
  logic [RW-1:0] d_old;
  logic [WW-1:0] s_way;
  logic s_hit, s_wb;
  logic [RW-1:0] s_old;
  logic s_valid;

  always_comb begin
    if (SB > 0) set_idx = SIW'(cur.addr >> OB);
    else set_idx = '0;
  end
  assign tag = TW'(cur.addr >> (OB + SB));
  assign vrow = valid_r[set_idx];
  assign drow = dirty_r[set_idx];
  always_comb begin
    for (int k = 0; k < WAYS; k++) rrow[k] = rank_r[set_idx][k];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (q_valid) state_next = ST_READ;
      ST_READ:   state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_WRITE;
      ST_WRITE:  state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop = 1'b0;
    unique case (state)
      ST_IDLE: q_pop = q_valid;
      default: q_pop = 1'b0;
    endcase
  end

  // capture request
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  // registered tag row read
  always_ff @(posedge clk) begin
    tag_row <= tag_mem[set_idx];
  end

  // classify: hit search, free way, victim
  always_comb begin
    logic [RW-1:0] best;
    d_hit = 1'b0;
    d_free = 1'b0;
    d_way = '0;
    best = '0;
    for (int k = WAYS - 1; k >= 0; k--) begin
      if (vrow[k] && tag_row[k] == tag) begin
        d_hit = 1'b1;
        d_way = WW'(k);
      end
    end
    if (!d_hit) begin
      for (int k = WAYS - 1; k >= 0; k--) begin
        if (!vrow[k]) begin
          d_free = 1'b1;
          d_way = WW'(k);
        end
      end
      if (!d_free) begin
        for (int k = 0; k < WAYS; k++) begin
          if (rrow[k] > best) begin
            best = rrow[k];
            d_way = WW'(k);
          end
        end
      end
    end
    d_old = (d_hit || !d_free) ? rrow[d_way] : RW'(WAYS);
    d_wb = !d_hit && !d_free && drow[d_way];
  end

  always_ff @(posedge clk) begin
    if (state == ST_DECIDE) begin
      s_way <= d_way;
      s_hit <= d_hit;
      s_wb <= d_wb;
      s_old <= d_old;
    end
  end
  assign s_valid = (state == ST_WRITE);

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NSETS; s++) begin
        valid_r[s] <= '0;
        dirty_r[s] <= '0;
        for (int k = 0; k < WAYS; k++) rank_r[s][k] <= '0;
      end
    end else if (s_valid) begin
      for (int k = 0; k < WAYS; k++) begin
        if (WW'(k) == s_way) rank_r[set_idx][k] <= '0;
        else if (vrow[k] && rrow[k] < s_old) rank_r[set_idx][k] <= rrow[k] + 1'b1;
      end
      valid_r[set_idx][s_way] <= 1'b1;
      if (!s_hit || cur.op == OP_WRITE) dirty_r[set_idx][s_way] <= cur.op;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && !s_hit) tag_mem[set_idx][s_way] <= tag;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= s_valid;
  end
  always_ff @(posedge clk) begin
    if (s_valid) begin
      is_write <= cur.op;
      hit <= s_hit;
      write_back <= s_wb;
      way_used <= WayOutW'(32'(s_way));
    end
  end
endmodule

// ===== rtl/set_assoc_lru_writeback_cache.sv =====
// Top level of the set-associative LRU write-back cache tag model.
// channel | signals                           | handshake
// command | op, addr                          | start && !busy
// result  | is_write, hit, write_back, way_used | done strobe, one cycle
// In the back end each command passes through pop, tag row read, decide and
// update; done strobes in the next cycle. The serial back end sets the rate.
// A two-entry queue takes commands while the back end works; busy when full.
// Synchronous reset clears valid, dirty and rank flops at once; tags undefined.
module set_assoc_lru_writeback_cache
  import salc_pkg::*;
#(
  parameter int SETS = 16,
  parameter int WAYS = 8,
  parameter int BLOCK_BYTES = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic op,
  input  logic [AddrW-1:0] addr,
  output logic done,
  output logic is_write,
  output logic hit,
  output logic write_back,
  output logic [WayOutW-1:0] way_used
);
  logic q_valid;
  logic q_pop;
  req_t q_data;

  salc_front u_front (
    .clk(clk), .rst(rst), .start(start), .op(op), .addr(addr),
    .busy(busy), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  salc_back #(.SETS(SETS), .WAYS(WAYS), .BLOCK_BYTES(BLOCK_BYTES)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .done(done), .is_write(is_write), .hit(hit), .write_back(write_back),
    .way_used(way_used)
  );
endmodule

// ===== rtl/salc_checker.sv =====
// Port-level checker for the cache, bound to the top level.
`include "set_assoc_lru_writeback_cache_assert.svh"
module salc_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic done,
  input logic hit,
  input logic write_back
);
  `SALC_ASSERT_IMP(a_hit_no_wb, done && hit, !write_back)
  `SALC_ASSERT_NXT(a_done_pulse, done, !done)
  `SALC_ASSERT_NXT(a_idle_after_reset, $fell(rst), !done)
  // queue comes out of reset empty
  `SALC_ASSERT_IMP(a_not_busy_after_reset, $fell(rst), !busy)
endmodule

bind set_assoc_lru_writeback_cache salc_checker u_salc_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done),
  .hit(hit), .write_back(write_back)
);
